>>> sv/assert_macros.svh
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/lruc_pkg.sv
// Package with types and constants of the generation-checked LRU cache.
package lruc_pkg;
  localparam int Entries = 16;
  localparam int IdxW = $clog2(Entries);
  localparam int RankW = IdxW;
  localparam int KeyW = 22;
  localparam int StampW = 48;
  localparam int DataW = 32;
  localparam int CntW = 32;
  localparam int CfgW = 5;

  typedef struct packed {
    logic [KeyW-1:0]   key_id;
    logic [StampW-1:0] gen_stamp;
    logic [DataW-1:0]  fill_data;
  } in_item_t;

  typedef struct packed {
    logic            hit;
    logic [DataW-1:0] data_out;
    logic            stale_dropped;
    logic            evicted;
    logic [CntW-1:0] lookup_total;
    logic [CntW-1:0] hit_total;
    logic [CntW-1:0] miss_total;
    logic [CntW-1:0] evict_total;
  } out_item_t;

  // One slot as it travels along the chain.
  typedef struct packed {
    logic              valid;
    logic [KeyW-1:0]   key;
    logic [StampW-1:0] stamp;
    logic [DataW-1:0]  data;
    logic [RankW-1:0]  rank;
  } slot_t;
endpackage

>>> sv/lruc_cell.sv
// One storage cell of the slot chain.
module lruc_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift,
  input  lruc_pkg::slot_t  slot_in,
  output lruc_pkg::slot_t  slot_out
);
  lruc_pkg::slot_t slot_r;
  logic valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= slot_in.valid;
    end
    if (shift) begin
      slot_r <= slot_in;
    end
  end

  always_comb begin
    slot_out = slot_r;
    slot_out.valid = valid_r;
    if (!valid_r) slot_out.rank = '0;
  end
endmodule

>>> sv/lruc_ctrl.sv
// Sequencer that walks the slot ring for search and update passes.
module lruc_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lruc_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lruc_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic [lruc_pkg::CfgW-1:0]     cfg_wdata,
  input  lruc_pkg::slot_t               head,
  output lruc_pkg::slot_t               tail_in,
  output logic                          shift
);
  localparam logic [1:0] StIdle = 2'd0, StScan = 2'd1, StUpd = 2'd2;
  localparam logic [lruc_pkg::CfgW-1:0] CapMax = lruc_pkg::CfgW'(lruc_pkg::Entries);
  localparam int PosW = lruc_pkg::IdxW + 1;

  logic [1:0] st_r, st_nxt;
  logic [lruc_pkg::CfgW-1:0] cfg_r;
  logic [PosW-1:0] pos_r, pos_nxt, cap_r;
  lruc_pkg::in_item_t req_r;
  logic found_r, found_nxt, stale_r, stale_nxt;
  logic [lruc_pkg::IdxW-1:0] fidx_r, fidx_nxt, free_r, free_nxt, old_r, old_nxt;
  logic have_free_r, have_free_nxt, have_old_r, have_old_nxt;
  logic [lruc_pkg::RankW-1:0] frank_r, frank_nxt, orank_r, orank_nxt;
  logic [lruc_pkg::DataW-1:0] fdata_r, fdata_nxt;
  logic [lruc_pkg::CntW-1:0] c_look_r, c_hit_r, c_miss_r, c_ev_r;
  logic out_valid_r;
  lruc_pkg::out_item_t out_r;
  logic [lruc_pkg::IdxW-1:0] idx;
  logic in_win, match, is_hit, evict, drop;
  logic [lruc_pkg::IdxW-1:0] tgt;
  logic [lruc_pkg::RankW-1:0] drank;
  lruc_pkg::slot_t upd;

  assign idx = pos_r[lruc_pkg::IdxW-1:0];
  assign in_win = (PosW'(idx) < cap_r);
  assign match = head.valid && head.key == req_r.key_id && in_win;
  assign is_hit = found_r && !stale_r;
  assign evict = !is_hit && !stale_r && !have_free_r;
  assign drop = stale_r || evict;
  assign drank = stale_r ? frank_r : orank_r;
  assign tgt = (is_hit || (stale_r && !(have_free_r && free_r < fidx_r))) ? fidx_r :
               (have_free_r ? free_r : old_r);

  assign in_ready = (st_r == StIdle) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_item = out_r;
  assign shift = (st_r != StIdle);

  always_comb begin
    st_nxt = st_r; pos_nxt = pos_r;
    found_nxt = found_r; stale_nxt = stale_r; fidx_nxt = fidx_r; frank_nxt = frank_r;
    fdata_nxt = fdata_r; free_nxt = free_r; have_free_nxt = have_free_r;
    old_nxt = old_r; have_old_nxt = have_old_r; orank_nxt = orank_r;
    upd = head;
    case (st_r)
      StIdle: begin
        if (in_valid && in_ready && cfg_r != '0) st_nxt = StScan;
      end
      StScan: begin
        if (match && !found_r) begin
          found_nxt = 1'b1; fidx_nxt = idx; frank_nxt = head.rank; fdata_nxt = head.data;
          stale_nxt = head.stamp != req_r.gen_stamp;
        end
        if (in_win && !head.valid && !have_free_r) begin
          have_free_nxt = 1'b1; free_nxt = idx;
        end
        if (in_win && head.valid && (!have_old_r || head.rank > orank_r)) begin
          have_old_nxt = 1'b1; old_nxt = idx; orank_nxt = head.rank;
        end
        pos_nxt = pos_r + 1'b1;
        if (idx == lruc_pkg::IdxW'(lruc_pkg::Entries - 1)) begin
          st_nxt = StUpd; pos_nxt = '0;
        end
      end
      StUpd: begin
        // A stale slot is refilled in place unless a free slot lies below it; then the fill
        // goes to that lowest free slot, leaving the stale slot empty.
        if (idx == tgt) begin
          if (is_hit) begin
            upd.rank = '0;
          end else begin
            upd.valid = 1'b1; upd.key = req_r.key_id; upd.stamp = req_r.gen_stamp;
            upd.data = req_r.fill_data; upd.rank = '0;
          end
        end else if (stale_r && idx == fidx_r) begin
          upd.valid = 1'b0; upd.rank = '0;
        end else if (head.valid) begin
          if (is_hit) begin
            if (head.rank < frank_r) upd.rank = head.rank + 1'b1;
          end else begin
            // drop closes gap, then promote ages every valid slot
            if (drop && head.rank > drank) upd.rank = head.rank;
            else upd.rank = head.rank + 1'b1;
          end
        end
        pos_nxt = pos_r + 1'b1;
        if (idx == lruc_pkg::IdxW'(lruc_pkg::Entries - 1)) begin
          st_nxt = StIdle; pos_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  assign tail_in = (st_r == StUpd) ? upd : head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle; pos_r <= '0; cfg_r <= CapMax; out_valid_r <= 1'b0;
      c_look_r <= '0; c_hit_r <= '0; c_miss_r <= '0; c_ev_r <= '0;
    end else begin
      if (cfg_we) cfg_r <= cfg_wdata;
      st_r <= st_nxt; pos_r <= pos_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (in_valid && in_ready && cfg_r == '0) begin
        out_valid_r <= 1'b1;
        out_r <= '{hit: 1'b0, data_out: in_item.fill_data, stale_dropped: 1'b0,
                   evicted: 1'b0, lookup_total: c_look_r, hit_total: c_hit_r,
                   miss_total: c_miss_r, evict_total: c_ev_r};
      end
      if (st_r == StUpd && st_nxt == StIdle) begin
        out_valid_r <= 1'b1;
        c_look_r <= c_look_r + 1'b1;
        if (is_hit) c_hit_r <= c_hit_r + 1'b1;
        else c_miss_r <= c_miss_r + 1'b1;
        if (evict) c_ev_r <= c_ev_r + 1'b1;
        out_r <= '{hit: is_hit, data_out: is_hit ? fdata_r : req_r.fill_data,
                   stale_dropped: stale_r, evicted: evict,
                   lookup_total: c_look_r + 1'b1,
                   hit_total: c_hit_r + lruc_pkg::CntW'(is_hit),
                   miss_total: c_miss_r + lruc_pkg::CntW'(!is_hit),
                   evict_total: c_ev_r + lruc_pkg::CntW'(evict)};
      end
    end
    if (in_valid && in_ready) begin
      req_r <= in_item;
      cap_r <= (cfg_r > CapMax) ? PosW'(lruc_pkg::Entries) : PosW'(cfg_r);
      found_r <= 1'b0; stale_r <= 1'b0; have_free_r <= 1'b0; have_old_r <= 1'b0;
      fidx_r <= '0; frank_r <= '0; fdata_r <= '0; free_r <= '0; old_r <= '0; orank_r <= '0;
    end else if (st_r == StScan) begin
      found_r <= found_nxt; stale_r <= stale_nxt; fidx_r <= fidx_nxt; frank_r <= frank_nxt;
      fdata_r <= fdata_nxt; free_r <= free_nxt; have_free_r <= have_free_nxt;
      old_r <= old_nxt; have_old_r <= have_old_nxt; orank_r <= orank_nxt;
    end
  end
endmodule

>>> sv/lru_cache_with_generation_check.sv
// Top level of the generation-checked, fully associative LRU cache.
// Requests arrive on the in_ channel (valid/ready); each transfer carries a key,
// a generation stamp and fill data. Exactly one result leaves on the out_ channel
// per request. The sixteen slots sit in a ring of cells that shifts by one every
// busy cycle: a search pass finds the matching, free and least recent slots,
// and an update pass rewrites keys, data and recency ranks; each pass visits
// every slot of the ring once. The next request is taken once the result has
// been transferred. With entries_in_use at zero the cache is bypassed and the
// result appears in the cycle after the transfer with the counters unchanged.
// The cfg_ port writes entries_in_use whenever cfg_we is high; the user must see
// that it is written only while the block is idle, as the block itself does not
// enforce this. Synchronous reset empties every slot, clears the counters and
// sets entries_in_use to sixteen. If the receiver stalls, the result is held
// and no new request is taken until it has been transferred.
`include "assert_macros.svh"
module lru_cache_with_generation_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lruc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lruc_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [lruc_pkg::CfgW-1:0]     cfg_wdata
);
  lruc_pkg::slot_t chain [lruc_pkg::Entries+1];
  lruc_pkg::slot_t head;
  logic shift;

  // Cell 0 holds the slot currently at the ring head; the tail feeds back.
  genvar g;
  for (g = 0; g < lruc_pkg::Entries; g++) begin : g_cell
    lruc_cell u_cell (.clk, .rst_n, .shift, .slot_in(chain[g+1]), .slot_out(chain[g]));
  end
  assign head = chain[0];

  lruc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_item(in_data), .out_valid, .out_ready,
    .out_item(out_data), .cfg_we, .cfg_wdata, .head, .tail_in(chain[lruc_pkg::Entries]),
    .shift
  );

  // A result waiting must keep the input closed.
  `ASSERT_IMPL(a_no_accept_while_full, clk, rst_n, out_valid, !in_ready)
  // A hit never reports an eviction or stale drop.
  `ASSERT_IMPL(a_hit_flags, clk, rst_n, out_valid && out_data.hit,
               !out_data.evicted && !out_data.stale_dropped)
  // Eviction and stale drop are exclusive.
  `ASSERT_IMPL(a_evict_stale, clk, rst_n, out_valid, !(out_data.evicted && out_data.stale_dropped))
endmodule
